[rtl/core/sphere_patch_vertex_generator_core_macros.svh]
// Assertion macros for the vertex generator RTL.
`ifndef SPHERE_PATCH_VERTEX_GENERATOR_CORE_MACROS_SVH
`define SPHERE_PATCH_VERTEX_GENERATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication check.
`define SPVG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// Next-cycle implication check.
`define SPVG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define SPVG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SPVG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/spvg_pkg.sv]
package spvg_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLAR_LO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLAR_HI   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AZIMUTH_LO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AZIMUTH_HI = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 3'd6;

  // Field widths.
  localparam int IDX_W  = 10;
  localparam int SIDE_W = 11;
  localparam int ANG_W  = 16;
  localparam int VIDX_W = 20;
  localparam int TEX_W  = 16;
  localparam int NORM_W = 16;
  localparam int POS_W  = 24;

  // Divider lanes: quotients are known to fit in QUO_W magnitude bits.
  localparam int QUO_W     = 16;
  localparam int NUM_W     = 26;
  localparam int DIV_LANES = 4;
  localparam int LANE_TH   = 0;
  localparam int LANE_PH   = 1;
  localparam int LANE_U    = 2;
  localparam int LANE_V    = 3;

  // CORDIC constants, angles in Q28 and vectors in Q30.
  localparam int CRD_STEPS = 24;
  localparam int CRD_W     = 34;
  localparam int TRIG_W    = 32;
  localparam int CRD_LANES = 2;
  localparam logic signed [32:0] PI_Q28      = 33'sd843314857;
  localparam logic signed [32:0] HALF_PI_Q28 = 33'sd421657428;
  localparam logic signed [32:0] TWO_PI_Q28  = 33'sd1686629714;
  localparam logic signed [CRD_W-1:0] GAIN_Q30 = 34'sd652032874;

  function automatic logic signed [31:0] atan_q28(input logic [4:0] k);
    logic signed [31:0] r;
    case (k)
      5'd0:  r = 32'sd210828714;
      5'd1:  r = 32'sd124459457;
      5'd2:  r = 32'sd65760959;
      5'd3:  r = 32'sd33381290;
      5'd4:  r = 32'sd16755422;
      5'd5:  r = 32'sd8385879;
      5'd6:  r = 32'sd4193963;
      5'd7:  r = 32'sd2097109;
      5'd8:  r = 32'sd1048571;
      5'd9:  r = 32'sd524287;
      5'd10: r = 32'sd262144;
      5'd11: r = 32'sd131072;
      5'd12: r = 32'sd65536;
      5'd13: r = 32'sd32768;
      5'd14: r = 32'sd16384;
      5'd15: r = 32'sd8192;
      5'd16: r = 32'sd4096;
      5'd17: r = 32'sd2048;
      5'd18: r = 32'sd1024;
      5'd19: r = 32'sd512;
      5'd20: r = 32'sd256;
      5'd21: r = 32'sd128;
      5'd22: r = 32'sd64;
      5'd23: r = 32'sd32;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // Side data that rides along the pipelines.
  typedef struct packed {
    logic              valid;
    logic [VIDX_W-1:0] vertex_index;
  } div_tag_t;

  typedef struct packed {
    logic              valid;
    logic [VIDX_W-1:0] vertex_index;
    logic [TEX_W-1:0]  tex_u;
    logic [TEX_W-1:0]  tex_v;
  } crd_tag_t;

endpackage

[rtl/core/spvg_div.sv]
module spvg_div import spvg_pkg::*; #(
  parameter int LANES = 4,
  parameter int TAG_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic [NUM_W-1:0]        num_i [LANES],
  input  logic                    neg_i [LANES],
  input  logic [SIDE_W-1:0]       den_i [LANES],
  input  logic [TAG_W-1:0]        tag_i,
  output logic signed [QUO_W:0]   quo_o [LANES],
  output logic [TAG_W-1:0]        tag_o
);

  logic [NUM_W-1:0] rem_q [QUO_W+1][LANES];
  logic [QUO_W-1:0] quo_q [QUO_W+1][LANES];
  logic             neg_q [QUO_W+1][LANES];
  logic [TAG_W-1:0] tag_q [QUO_W+1];

  // Input register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[0][l] <= num_i[l];
        quo_q[0][l] <= '0;
        neg_q[0][l] <= neg_i[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
    end else if (en_i) begin
      tag_q[0] <= tag_i;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 1; s <= QUO_W; s++) begin : g_step
    localparam int K = QUO_W - s;
    logic [NUM_W:0]   trial [LANES];
    logic [QUO_W-1:0] qn [LANES];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {1'b0, rem_q[s-1][l]}
                 - ({{(NUM_W+1-SIDE_W){1'b0}}, den_i[l]} << K);
        qn[l]    = quo_q[s-1][l];
        qn[l][K] = !trial[l][NUM_W];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < LANES; l++) begin
          rem_q[s][l] <= trial[l][NUM_W] ? rem_q[s-1][l] : trial[l][NUM_W-1:0];
          quo_q[s][l] <= qn[l];
          neg_q[s][l] <= neg_q[s-1][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else if (en_i) begin
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  // Apply the sign; the quotient truncates toward zero.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_o[l] = neg_q[QUO_W][l] ? -$signed({1'b0, quo_q[QUO_W][l]})
                                 :  $signed({1'b0, quo_q[QUO_W][l]});
    end
  end

  assign tag_o = tag_q[QUO_W];

endmodule

[rtl/core/spvg_cordic.sv]
module spvg_cordic import spvg_pkg::*; #(
  parameter int LANES = 2,
  parameter int TAG_W = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic signed [ANG_W-1:0]  angle_i [LANES],
  input  logic [TAG_W-1:0]         tag_i,
  output logic signed [TRIG_W-1:0] sin_o [LANES],
  output logic signed [TRIG_W-1:0] cos_o [LANES],
  output logic [TAG_W-1:0]         tag_o
);

  logic signed [CRD_W-1:0] x_q [CRD_STEPS+1][LANES];
  logic signed [CRD_W-1:0] y_q [CRD_STEPS+1][LANES];
  logic signed [31:0]      a_q [CRD_STEPS+1][LANES];
  logic                    flip_q [CRD_STEPS+1][LANES];
  logic [TAG_W-1:0]        tag_q [CRD_STEPS+1];
  logic signed [32:0]      red_a [LANES];
  logic signed [32:0]      fold_a [LANES];
  logic                    fold_flip [LANES];
  logic signed [CRD_W-1:0] neg_x [LANES];
  logic [TAG_W-1:0]        tag_out_q;

  // Bring the angle into [-pi, pi], then fold into [-pi/2, pi/2].
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      red_a[l] = {angle_i[l][ANG_W-1], angle_i[l], 16'b0};
      if (red_a[l] > PI_Q28) begin
        red_a[l] = red_a[l] - TWO_PI_Q28;
      end else if (red_a[l] < -PI_Q28) begin
        red_a[l] = red_a[l] + TWO_PI_Q28;
      end
      fold_a[l]    = red_a[l];
      fold_flip[l] = 1'b0;
      if (red_a[l] > HALF_PI_Q28) begin
        fold_a[l]    = PI_Q28 - red_a[l];
        fold_flip[l] = 1'b1;
      end else if (red_a[l] < -HALF_PI_Q28) begin
        fold_a[l]    = -PI_Q28 - red_a[l];
        fold_flip[l] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        a_q[0][l]    <= fold_a[l][31:0];
        x_q[0][l]    <= GAIN_Q30;
        y_q[0][l]    <= '0;
        flip_q[0][l] <= fold_flip[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
    end else if (en_i) begin
      tag_q[0] <= tag_i;
    end
  end

  // One rotation per stage; the shifts round toward minus infinity.
  for (genvar s = 1; s <= CRD_STEPS; s++) begin : g_rot
    localparam int K = s - 1;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < LANES; l++) begin
          if (!a_q[s-1][l][31]) begin
            x_q[s][l] <= x_q[s-1][l] - (y_q[s-1][l] >>> K);
            y_q[s][l] <= y_q[s-1][l] + (x_q[s-1][l] >>> K);
            a_q[s][l] <= a_q[s-1][l] - atan_q28(5'(K));
          end else begin
            x_q[s][l] <= x_q[s-1][l] + (y_q[s-1][l] >>> K);
            y_q[s][l] <= y_q[s-1][l] - (x_q[s-1][l] >>> K);
            a_q[s][l] <= a_q[s-1][l] + atan_q28(5'(K));
          end
          flip_q[s][l] <= flip_q[s-1][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else if (en_i) begin
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  // Output register; the fold negates the cosine.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      neg_x[l] = -x_q[CRD_STEPS][l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        sin_o[l] <= y_q[CRD_STEPS][l][TRIG_W-1:0];
        cos_o[l] <= flip_q[CRD_STEPS][l] ? neg_x[l][TRIG_W-1:0]
                                         : x_q[CRD_STEPS][l][TRIG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_out_q <= '0;
    end else if (en_i) begin
      tag_out_q <= tag_q[CRD_STEPS];
    end
  end

  assign tag_o = tag_out_q;

endmodule

[rtl/core/sphere_patch_vertex_generator_core.sv]
// Sphere patch vertex generator. Each input transaction names a lattice point
// (column, row) and yields one output transaction with the vertex index,
// position, unit normal and texture coordinates of that point on the sphere
// patch set by the configuration registers. The block is fully pipelined: a
// new transaction can enter in every clock cycle unless the output stalls. The
// pipeline holds the 17-stage bit-per-stage divider that forms the angle
// steps and texture coordinates, the 26-stage CORDIC that produces sine and
// cosine, and the multiply stages for the normal and position. A stall at
// the output while a result is held freezes the whole pipeline. The
// configuration port is always ready and should be written only while no
// transaction is in flight.
`include "sphere_patch_vertex_generator_core_macros.svh"

module sphere_patch_vertex_generator_core import spvg_pkg::*; #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write channel.
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [15:0]              cfg_data_i,
  // Input channel.
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [IDX_W-1:0]         column_index_i,
  input  logic [IDX_W-1:0]         row_index_i,
  // Output channel.
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [VIDX_W-1:0]        vertex_index_o,
  output logic signed [POS_W-1:0]  pos_x_o,
  output logic signed [POS_W-1:0]  pos_y_o,
  output logic signed [POS_W-1:0]  pos_z_o,
  output logic signed [NORM_W-1:0] norm_x_o,
  output logic signed [NORM_W-1:0] norm_y_o,
  output logic signed [NORM_W-1:0] norm_z_o,
  output logic [TEX_W-1:0]         tex_u_o,
  output logic [TEX_W-1:0]         tex_v_o
);

  localparam int SIDE_CAP_I = (MAX_SIDE > 2047) ? 2047 : MAX_SIDE;
  localparam logic [SIDE_W-1:0] SIDE_CAP = SIDE_W'(SIDE_CAP_I);

  // Configuration registers.
  logic [15:0]              radius_q;
  logic signed [ANG_W-1:0]  polar_lo_q, polar_hi_q, az_lo_q, az_hi_q;
  logic [SIDE_W-1:0]        columns_q, rows_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= 16'd256;
      polar_lo_q <= '0;
      polar_hi_q <= 16'sd12868;
      az_lo_q    <= '0;
      az_hi_q    <= 16'sd25736;
      columns_q  <= 11'd2;
      rows_q     <= 11'd2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_RADIUS:     radius_q   <= cfg_data_i;
        REG_POLAR_LO:   polar_lo_q <= cfg_data_i;
        REG_POLAR_HI:   polar_hi_q <= cfg_data_i;
        REG_AZIMUTH_LO: az_lo_q    <= cfg_data_i;
        REG_AZIMUTH_HI: az_hi_q    <= cfg_data_i;
        REG_COLUMNS:    columns_q  <= cfg_data_i[SIDE_W-1:0];
        REG_ROWS:       rows_q     <= cfg_data_i[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective side counts, clamped into [2, MAX_SIDE], with MAX_SIDE capped at 2047.
  logic [SIDE_W-1:0] nc, nr, ncm1, nrm1;

  always_comb begin
    nc = columns_q;
    if (columns_q < 11'd2) begin
      nc = 11'd2;
    end else if (columns_q > SIDE_CAP) begin
      nc = SIDE_CAP;
    end
    nr = rows_q;
    if (rows_q < 11'd2) begin
      nr = 11'd2;
    end else if (rows_q > SIDE_CAP) begin
      nr = SIDE_CAP;
    end
    ncm1 = nc - 11'd1;
    nrm1 = nr - 11'd1;
  end

  // The whole pipeline advances unless a finished result is held.
  logic en;
  logic o_valid_q;

  assign en         = !(o_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Stage A: clamp the indexes and form the angle spans.
  logic              a_valid_q;
  logic [IDX_W-1:0]  a_i_q, a_j_q;
  logic [15:0]       a_th_mag_q, a_ph_mag_q;
  logic              a_th_neg_q, a_ph_neg_q;
  logic signed [16:0] dth, dph;

  assign dth = {polar_hi_q[ANG_W-1], polar_hi_q} - {polar_lo_q[ANG_W-1], polar_lo_q};
  assign dph = {az_hi_q[ANG_W-1], az_hi_q} - {az_lo_q[ANG_W-1], az_lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_i_q      <= ({1'b0, column_index_i} > ncm1) ? ncm1[IDX_W-1:0] : column_index_i;
      a_j_q      <= ({1'b0, row_index_i} > nrm1) ? nrm1[IDX_W-1:0] : row_index_i;
      a_th_neg_q <= dth[16];
      a_ph_neg_q <= dph[16];
      a_th_mag_q <= dth[16] ? 16'(-dth) : dth[15:0];
      a_ph_mag_q <= dph[16] ? 16'(-dph) : dph[15:0];
    end
  end

  // Stage B: numerators for the divider and the linear index.
  logic [NUM_W-1:0] b_num_q [DIV_LANES];
  logic             b_neg_q [DIV_LANES];
  logic [SIDE_W-1:0] div_den [DIV_LANES];
  div_tag_t         b_tag_q;
  logic [20:0]      vidx_full;

  assign vidx_full = {11'b0, a_i_q} + (21'(a_j_q) * 21'(nc));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_tag_q <= '0;
    end else if (en) begin
      b_tag_q.valid        <= a_valid_q;
      b_tag_q.vertex_index <= vidx_full[VIDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_num_q[LANE_TH] <= NUM_W'(a_j_q) * NUM_W'(a_th_mag_q);
      b_num_q[LANE_PH] <= NUM_W'(a_i_q) * NUM_W'(a_ph_mag_q);
      b_num_q[LANE_U]  <= {1'b0, a_i_q, 15'b0};
      b_num_q[LANE_V]  <= {1'b0, a_j_q, 15'b0};
      b_neg_q[LANE_TH] <= a_th_neg_q;
      b_neg_q[LANE_PH] <= a_ph_neg_q;
      b_neg_q[LANE_U]  <= 1'b0;
      b_neg_q[LANE_V]  <= 1'b0;
    end
  end

  assign div_den[LANE_TH] = nrm1;
  assign div_den[LANE_PH] = ncm1;
  assign div_den[LANE_U]  = ncm1;
  assign div_den[LANE_V]  = nrm1;

  logic signed [QUO_W:0] quo [DIV_LANES];
  div_tag_t              div_tag;

  spvg_div #(
    .LANES (DIV_LANES),
    .TAG_W ($bits(div_tag_t))
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .num_i  (b_num_q),
    .neg_i  (b_neg_q),
    .den_i  (div_den),
    .tag_i  (b_tag_q),
    .quo_o  (quo),
    .tag_o  (div_tag)
  );

  // Stage C: the two angles and the texture coordinates.
  logic signed [ANG_W-1:0] c_angle_q [CRD_LANES];
  crd_tag_t                c_tag_q;
  logic signed [16:0]      theta_full, phi_full;

  assign theta_full = {polar_hi_q[ANG_W-1], polar_hi_q} - quo[LANE_TH];
  assign phi_full   = {az_lo_q[ANG_W-1], az_lo_q} + quo[LANE_PH];

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_angle_q[0] <= theta_full[ANG_W-1:0];
      c_angle_q[1] <= phi_full[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_tag_q <= '0;
    end else if (en) begin
      c_tag_q.valid        <= div_tag.valid;
      c_tag_q.vertex_index <= div_tag.vertex_index;
      c_tag_q.tex_u        <= quo[LANE_U][TEX_W-1:0];
      c_tag_q.tex_v        <= quo[LANE_V][TEX_W-1:0];
    end
  end

  // Sine and cosine of theta (lane 0) and phi (lane 1).
  logic signed [TRIG_W-1:0] sin_v [CRD_LANES];
  logic signed [TRIG_W-1:0] cos_v [CRD_LANES];
  crd_tag_t                 crd_tag;

  spvg_cordic #(
    .LANES (CRD_LANES),
    .TAG_W ($bits(crd_tag_t))
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .angle_i (c_angle_q),
    .tag_i   (c_tag_q),
    .sin_o   (sin_v),
    .cos_o   (cos_v),
    .tag_o   (crd_tag)
  );

  // Stage M1: products of the normal in Q60.
  logic signed [63:0] m1_px_q, m1_py_q;
  logic signed [TRIG_W-1:0] m1_ct_q;
  crd_tag_t           m1_tag_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_px_q <= 64'(sin_v[0]) * 64'(cos_v[1]);
      m1_py_q <= 64'(sin_v[0]) * 64'(sin_v[1]);
      m1_ct_q <= cos_v[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_tag_q <= '0;
    end else if (en) begin
      m1_tag_q <= crd_tag;
    end
  end

  // Stage M2: normal in Q30, truncated toward zero, and packed Q1.15 normals.
  logic signed [63:0] px_rnd, py_rnd, px_sh, py_sh;
  logic signed [32:0] m2_n_q [3];
  logic signed [32:0] n_next [3];
  logic signed [17:0] nshift [3];
  logic signed [32:0] nround [3];
  logic signed [NORM_W-1:0] norm_next [3];
  logic signed [NORM_W-1:0] m2_norm_q [3];
  crd_tag_t           m2_tag_q;

  always_comb begin
    px_rnd = m1_px_q + (m1_px_q[63] ? 64'sd1073741823 : 64'sd0);
    py_rnd = m1_py_q + (m1_py_q[63] ? 64'sd1073741823 : 64'sd0);
    px_sh  = px_rnd >>> 30;
    py_sh  = py_rnd >>> 30;
    n_next[0] = px_sh[32:0];
    n_next[1] = py_sh[32:0];
    n_next[2] = 33'(m1_ct_q);
    for (int k = 0; k < 3; k++) begin
      nround[k] = n_next[k] + (n_next[k][32] ? 33'sd32767 : 33'sd0);
      nshift[k] = nround[k][32:15];
      if (nshift[k] > 18'sd32767) begin
        norm_next[k] = 16'sh7FFF;
      end else if (nshift[k] < -18'sd32768) begin
        norm_next[k] = 16'sh8000;
      end else begin
        norm_next[k] = nshift[k][NORM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m2_n_q[k]    <= n_next[k];
        m2_norm_q[k] <= norm_next[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_tag_q <= '0;
    end else if (en) begin
      m2_tag_q <= m1_tag_q;
    end
  end

  // Stage M3: scale the normal by the radius.
  logic signed [49:0] m3_p_q [3];
  logic signed [NORM_W-1:0] m3_norm_q [3];
  crd_tag_t           m3_tag_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m3_p_q[k]    <= $signed({34'b0, radius_q}) * 50'(m2_n_q[k]);
        m3_norm_q[k] <= m2_norm_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_tag_q <= '0;
    end else if (en) begin
      m3_tag_q <= m2_tag_q;
    end
  end

  // Output register: position in Q15.8, truncated toward zero.
  logic signed [49:0]      p_rnd [3];
  logic signed [19:0]      p_sh [3];
  logic signed [POS_W-1:0] pos_next [3];
  logic signed [POS_W-1:0] o_pos_q [3];
  logic signed [NORM_W-1:0] o_norm_q [3];
  logic [VIDX_W-1:0]       o_vidx_q;
  logic [TEX_W-1:0]        o_u_q, o_v_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p_rnd[k]    = m3_p_q[k] + (m3_p_q[k][49] ? 50'sd1073741823 : 50'sd0);
      p_sh[k]     = p_rnd[k][49:30];
      pos_next[k] = POS_W'(p_sh[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (en) begin
      o_valid_q <= m3_tag_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        o_pos_q[k]  <= pos_next[k];
        o_norm_q[k] <= m3_norm_q[k];
      end
      o_vidx_q <= m3_tag_q.vertex_index;
      o_u_q    <= m3_tag_q.tex_u;
      o_v_q    <= m3_tag_q.tex_v;
    end
  end

  assign out_valid_o    = o_valid_q;
  assign vertex_index_o = o_vidx_q;
  assign pos_x_o        = o_pos_q[0];
  assign pos_y_o        = o_pos_q[1];
  assign pos_z_o        = o_pos_q[2];
  assign norm_x_o       = o_norm_q[0];
  assign norm_y_o       = o_norm_q[1];
  assign norm_z_o       = o_norm_q[2];
  assign tex_u_o        = o_u_q;
  assign tex_v_o        = o_v_q;

  // An accepted transaction always occupies the first stage next cycle.
  `SPVG_ASSERT_NEXT(a_accept_fills_stage_a, clk_i, rst_ni, in_valid_i && !in_stall_o, a_valid_q)
  // A stall freezes the middle of the pipeline.
  `SPVG_ASSERT_NEXT(a_stall_holds_angles, clk_i, rst_ni, in_stall_o, $stable(c_tag_q))
  // Clamped indexes keep texture coordinates within one.
  `SPVG_ASSERT_IMPLY(a_tex_in_range, clk_i, rst_ni, out_valid_o, tex_u_o <= 16'h8000 && tex_v_o <= 16'h8000)

endmodule

[verif/tb_sphere_patch_vertex_generator_core.sv]
`timescale 1ns / 1ps

module tb_sphere_patch_vertex_generator_core;
  import spvg_pkg::*;

  localparam int LATENCY = 50;
  localparam int SIDE_LIMIT = 1024;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam longint PI_Q28_L = 843314857;
  localparam longint HALF_PI_Q28_L = 421657428;
  localparam longint GAIN_Q30_L = 652032874;

  typedef struct {
    logic [VIDX_W-1:0] vertex_index;
    logic [POS_W-1:0]  pos_x, pos_y, pos_z;
    logic [NORM_W-1:0] norm_x, norm_y, norm_z;
    logic [TEX_W-1:0]  tex_u, tex_v;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic [IDX_W-1:0] column_index_i = '0;
  logic [IDX_W-1:0] row_index_i = '0;
  logic out_stall_i = 1'b0;
  logic cfg_ready_o, in_stall_o, out_valid_o;
  logic [VIDX_W-1:0] vertex_index_o;
  logic [POS_W-1:0] pos_x_o, pos_y_o, pos_z_o;
  logic [NORM_W-1:0] norm_x_o, norm_y_o, norm_z_o;
  logic [TEX_W-1:0] tex_u_o, tex_v_o;

  // Shadow copy of the configuration registers.
  logic [15:0] radius_q = 16'd256;
  logic [15:0] polar_lo_q = 16'd0;
  logic [15:0] polar_hi_q = 16'd12868;
  logic [15:0] azim_lo_q = 16'd0;
  logic [15:0] azim_hi_q = 16'd25736;
  logic [SIDE_W-1:0] columns_q = 11'd2;
  logic [SIDE_W-1:0] rows_q = 11'd2;

  vertex_t pending_vertices[$];
  int unsigned fail_count = 0;
  bit quiet = 1'b0;

  sphere_patch_vertex_generator_core dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint side_of(logic [SIDE_W-1:0] n);
    if (n < 2) return 2;
    if (n > SIDE_LIMIT) return SIDE_LIMIT;
    return n;
  endfunction

  function automatic longint shift_toward_zero(longint v, int k);
    if (v >= 0) return v >>> k;
    return -((-v) >>> k);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Range reduction, quadrant fold and 24 CORDIC rotations; results in Q30.
  function automatic void rotate_angle(longint ang_q12, output longint s, output longint c);
    longint a, x, y, dx, dy;
    bit flip;
    longint atan_tab[24] = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                             4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
                             32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
    a = ang_q12 * 65536;
    x = GAIN_Q30_L;
    y = 0;
    flip = 1'b0;
    if (a > PI_Q28_L) a -= 2 * PI_Q28_L;
    else if (a < -PI_Q28_L) a += 2 * PI_Q28_L;
    if (a > HALF_PI_Q28_L) begin
      a = PI_Q28_L - a;
      flip = 1'b1;
    end else if (a < -HALF_PI_Q28_L) begin
      a = -PI_Q28_L - a;
      flip = 1'b1;
    end
    for (int k = 0; k < 24; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (a >= 0) begin
        x -= dx; y += dy; a -= atan_tab[k];
      end else begin
        x += dx; y -= dy; a += atan_tab[k];
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic longint to_pos(longint n30);
    return clip(shift_toward_zero(longint'(radius_q) * n30, 30), -8388608, 8388607);
  endfunction

  function automatic longint to_norm(longint n30);
    return clip(shift_toward_zero(n30, 15), -32768, 32767);
  endfunction

  // Expected vertex for one lattice point under the current register settings.
  function automatic vertex_t predict_vertex(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
    vertex_t v;
    longint nc, nr, i, j, th_hi, th_lo, ph_hi, ph_lo, theta, phi, st, ct, sp, cp, nx, ny;
    nc = side_of(columns_q);
    nr = side_of(rows_q);
    i = (col > nc - 1) ? nc - 1 : col;
    j = (row > nr - 1) ? nr - 1 : row;
    th_hi = longint'($signed(polar_hi_q));
    th_lo = longint'($signed(polar_lo_q));
    ph_hi = longint'($signed(azim_hi_q));
    ph_lo = longint'($signed(azim_lo_q));
    theta = th_hi - (j * (th_hi - th_lo)) / (nr - 1);
    phi = ph_lo + (i * (ph_hi - ph_lo)) / (nc - 1);
    rotate_angle(theta, st, ct);
    rotate_angle(phi, sp, cp);
    nx = shift_toward_zero(st * cp, 30);
    ny = shift_toward_zero(st * sp, 30);
    v.vertex_index = VIDX_W'(i + j * nc);
    v.pos_x = POS_W'(to_pos(nx));
    v.pos_y = POS_W'(to_pos(ny));
    v.pos_z = POS_W'(to_pos(ct));
    v.norm_x = NORM_W'(to_norm(nx));
    v.norm_y = NORM_W'(to_norm(ny));
    v.norm_z = NORM_W'(to_norm(ct));
    v.tex_u = TEX_W'((i * 32768) / (nc - 1));
    v.tex_v = TEX_W'((j * 32768) / (nr - 1));
    return v;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Output side: compare each accepted transaction with the oldest expectation.
  always @(posedge clk_i) begin
    vertex_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_vertices.size() == 0) begin
        $error("output transaction with no expected vertex");
        fail_count++;
      end else begin
        e = pending_vertices.pop_front();
        check_field("vertex_index", e.vertex_index, vertex_index_o);
        check_field("pos_x", e.pos_x, pos_x_o);
        check_field("pos_y", e.pos_y, pos_y_o);
        check_field("pos_z", e.pos_z, pos_z_o);
        check_field("norm_x", e.norm_x, norm_x_o);
        check_field("norm_y", e.norm_y, norm_y_o);
        check_field("norm_z", e.norm_z, norm_z_o);
        check_field("tex_u", e.tex_u, tex_u_o);
        check_field("tex_v", e.tex_v, tex_v_o);
      end
    end
  end

  // Random output stalls, none during a quiet stretch.
  always @(negedge clk_i) out_stall_i <= !quiet && ($urandom_range(0, 99) < 9);

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_RADIUS:     radius_q = data;
      REG_POLAR_LO:   polar_lo_q = data;
      REG_POLAR_HI:   polar_hi_q = data;
      REG_AZIMUTH_LO: azim_lo_q = data;
      REG_AZIMUTH_HI: azim_hi_q = data;
      REG_COLUMNS:    columns_q = data[SIDE_W-1:0];
      REG_ROWS:       rows_q = data[SIDE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_point(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    column_index_i = col;
    row_index_i = row;
    do @(posedge clk_i); while (in_stall_o);
    pending_vertices.insert(pending_vertices.size(), predict_vertex(col, row));
  endtask

  // Lower valid and wait until every expected vertex has come out.
  task automatic drain;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
  endtask

  task automatic test_reset_settings;
    send_point(0, 0);
    send_point(1, 1);
    send_point(1023, 1023);
    send_point(1, 0);
    drain();
  endtask

  task automatic test_corners;
    write_reg(REG_RADIUS, 16'hFFFF);
    write_reg(REG_POLAR_LO, 16'h8000);
    write_reg(REG_POLAR_HI, 16'h7FFF);
    write_reg(REG_AZIMUTH_LO, 16'h7FFF);
    write_reg(REG_AZIMUTH_HI, 16'h8000);
    write_reg(REG_COLUMNS, 16'd1024);
    write_reg(REG_ROWS, 16'd1024);
    write_reg(REG_SPARE, 16'h1234);
    send_point(0, 0);
    send_point(1023, 1023);
    send_point(511, 512);
    send_point(1023, 0);
    send_point(0, 1023);
    drain();
    // Side counts below two and above the limit; indexes past the lattice.
    write_reg(REG_COLUMNS, 16'd0);
    write_reg(REG_ROWS, 16'h07FF);
    send_point(5, 5);
    send_point(1, 1023);
    drain();
    write_reg(REG_COLUMNS, 16'd1);
    write_reg(REG_ROWS, 16'd1025);
    write_reg(REG_RADIUS, 16'd0);
    send_point(3, 700);
    send_point(0, 1023);
    drain();
    // Equal angle bounds and the smallest nonzero radius.
    write_reg(REG_RADIUS, 16'd1);
    write_reg(REG_POLAR_LO, 16'd6434);
    write_reg(REG_POLAR_HI, 16'd6434);
    write_reg(REG_AZIMUTH_LO, 16'd0);
    write_reg(REG_AZIMUTH_HI, 16'd0);
    write_reg(REG_COLUMNS, 16'd3);
    write_reg(REG_ROWS, 16'd7);
    send_point(2, 6);
    send_point(0, 3);
    send_point(1023, 1023);
    drain();
  endtask

  task automatic random_settings(int phase);
    write_reg(REG_RADIUS, (phase == 0) ? 16'hFFFF : 16'($urandom));
    write_reg(REG_POLAR_LO, 16'($urandom));
    write_reg(REG_POLAR_HI, 16'($urandom));
    write_reg(REG_AZIMUTH_LO, 16'($urandom));
    write_reg(REG_AZIMUTH_HI, 16'($urandom));
    write_reg(REG_COLUMNS, (phase == 1) ? 16'd2 : 16'($urandom_range(0, 1100)));
    write_reg(REG_ROWS, (phase == 1) ? 16'd1024 : 16'($urandom_range(0, 1100)));
  endtask

  task automatic test_random_lattice;
    longint nc, nr;
    for (int phase = 0; phase < 7; phase++) begin
      random_settings(phase);
      quiet = (phase == 3);
      nc = side_of(columns_q);
      nr = side_of(rows_q);
      for (int n = 0; n < 250; n++) begin
        if ($urandom_range(0, 4) == 0) send_point(10'($urandom), 10'($urandom));
        else send_point(10'($urandom_range(0, nc - 1)), 10'($urandom_range(0, nr - 1)));
        // Hold off once mid-phase until the pipeline has emptied.
        if (n == 125 && phase == 2) begin
          @(negedge clk_i);
          in_valid_i = 1'b0;
          while (pending_vertices.size() != 0) @(posedge clk_i);
        end
      end
      quiet = 1'b0;
      drain();
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_settings();
    test_corners();
    test_random_lattice();
    if (fail_count == 0 && pending_vertices.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/spvg_pkg.sv
rtl/core/spvg_div.sv
rtl/core/spvg_cordic.sv
rtl/core/sphere_patch_vertex_generator_core.sv
verif/tb_sphere_patch_vertex_generator_core.sv
